// File: hw/rtl/pm_sensor_frame_parser_assert.svh
// Assertion macros for the RTL, included by the emitter.
`ifndef PM_SENSOR_FRAME_PARSER_ASSERT_SVH
`define PM_SENSOR_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define PMSFP_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pmsfp assertion failed");
// Checked property, also live during reset.
`define PMSFP_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("pmsfp assertion failed");
`else
`define PMSFP_ASSERT(name, clk, rstn, prop)
`define PMSFP_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: hw/rtl/pmsfp_pkg.sv
`timescale 1ns / 1ps

package pmsfp_pkg;

    // frame markers and lengths
    localparam logic [7:0]  START_A   = 8'h42;
    localparam logic [7:0]  START_B   = 8'h4D;
    localparam logic [15:0] LEN_SHORT = 16'(2 * 9 + 2);
    localparam logic [15:0] LEN_LONG  = 16'(2 * 13 + 2);

    // byte positions within a frame
    localparam logic [4:0] POS_SYNC_A   = 5'd0;
    localparam logic [4:0] POS_SYNC_B   = 5'd1;
    localparam logic [4:0] POS_LEN_HI   = 5'd2;
    localparam logic [4:0] POS_LEN_LO   = 5'd3;
    localparam logic [4:0] POS_PAYLOAD  = 5'd4;
    localparam logic [4:0] CK_POS_SHORT = 5'(LEN_SHORT + 16'd2);
    localparam logic [4:0] CK_POS_LONG  = 5'(LEN_LONG + 16'd2);

    // result indexes
    localparam logic [3:0] HCHO_INDEX = 4'd12;
    localparam logic [3:0] LAST_INDEX = 4'd14;
    localparam logic [3:0] DERIVED_OFFSET = 4'd3;  // 13 -> word 10, 14 -> word 11

    // x / 1000 and x / 10 for 16-bit x by reciprocal multiply
    localparam logic [16:0] HCHO_MULT  = 17'd67109;
    localparam int          HCHO_SHIFT = 26;
    localparam logic [16:0] TH_MULT    = 17'd52429;
    localparam int          TH_SHIFT   = 19;

    typedef struct packed {
        logic       en;
        logic [4:0] idx;   // payload byte number
        logic [7:0] data;
    } pay_wr_t;

    typedef struct packed {
        logic       en;
        logic [3:0] word;  // payload word number
    } pay_rd_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_OUT
    } emit_state_t;

    function automatic logic [3:0] word_of(input logic [3:0] result_idx);
        logic [3:0] w;
        if (result_idx > HCHO_INDEX) begin
            w = result_idx - DERIVED_OFFSET;
        end else begin
            w = result_idx;
        end
        return w;
    endfunction

endpackage

// File: hw/rtl/pmsfp_ram.sv
`timescale 1ns / 1ps

module pmsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pmsfp_store.sv
`timescale 1ns / 1ps

// Payload store: even bytes and odd bytes in separate banks so that one
// read returns a whole big-endian word. Entries never written read as zero.
module pmsfp_store #(
    parameter int PAYLOAD_BYTES = 26
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pmsfp_pkg::pay_wr_t wr,
    input  pmsfp_pkg::pay_rd_t rd,
    output logic [15:0]       rd_word
);

    localparam int BANK_DEPTH = (PAYLOAD_BYTES + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    logic                  in_range;
    logic                  even_we;
    logic                  odd_we;
    logic [BANK_AW-1:0]    waddr;
    logic [BANK_AW-1:0]    raddr;
    logic [7:0]            even_q;
    logic [7:0]            odd_q;
    logic [BANK_DEPTH-1:0] even_vld_reg;
    logic [BANK_DEPTH-1:0] odd_vld_reg;
    logic                  even_rv_reg;
    logic                  odd_rv_reg;

    assign in_range = 6'(wr.idx) < 6'(PAYLOAD_BYTES);
    assign even_we  = wr.en && in_range && !wr.idx[0];
    assign odd_we   = wr.en && in_range && wr.idx[0];
    assign waddr    = wr.idx[BANK_AW:1];
    assign raddr    = rd.word[BANK_AW-1:0];

    pmsfp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
        .aclk  (aclk),
        .we    (even_we),
        .waddr (waddr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (raddr),
        .rdata (even_q)
    );

    pmsfp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
        .aclk  (aclk),
        .we    (odd_we),
        .waddr (waddr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (raddr),
        .rdata (odd_q)
    );

    // written flags give the all-zero reset contents without a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            even_vld_reg <= '0;
            odd_vld_reg  <= '0;
            even_rv_reg  <= 1'b0;
            odd_rv_reg   <= 1'b0;
        end else begin
            if (even_we) begin
                even_vld_reg[waddr] <= 1'b1;
            end
            if (odd_we) begin
                odd_vld_reg[waddr] <= 1'b1;
            end
            if (rd.en) begin
                even_rv_reg <= even_vld_reg[raddr];
                odd_rv_reg  <= odd_vld_reg[raddr];
            end
        end
    end

    assign rd_word = {(even_rv_reg ? even_q : 8'h00), (odd_rv_reg ? odd_q : 8'h00)};

endmodule

// File: hw/rtl/pmsfp_parser.sv
`timescale 1ns / 1ps

// Byte-level frame parser: sync hunt, length check, running sum, payload
// writes and checksum compare.
module pmsfp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output pmsfp_pkg::pay_wr_t wr,
    output logic               start
);

    logic [4:0]  pos_reg,    pos_next;
    logic [15:0] sum_reg,    sum_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        long_reg,   long_next;
    logic [7:0]  ck_hi_reg,  ck_hi_next;

    logic [4:0]  ck_pos;
    logic [15:0] len_word;
    logic [15:0] sum_add;

    assign ck_pos   = long_reg ? pmsfp_pkg::CK_POS_LONG : pmsfp_pkg::CK_POS_SHORT;
    assign len_word = {len_hi_reg, rx_byte};
    assign sum_add  = sum_reg + {8'h00, rx_byte};

    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        len_hi_next = len_hi_reg;
        long_next   = long_reg;
        ck_hi_next  = ck_hi_reg;
        start       = 1'b0;
        wr.en       = 1'b0;
        wr.idx      = pos_reg - pmsfp_pkg::POS_PAYLOAD;
        wr.data     = rx_byte;
        if (accept) begin
            case (pos_reg)
                pmsfp_pkg::POS_SYNC_A: begin
                    if (rx_byte == pmsfp_pkg::START_A) begin
                        sum_next = {8'h00, rx_byte};
                        pos_next = pmsfp_pkg::POS_SYNC_B;
                    end
                end
                pmsfp_pkg::POS_SYNC_B: begin
                    // a bad second byte is not retried as a first byte
                    if (rx_byte == pmsfp_pkg::START_B) begin
                        sum_next = sum_add;
                        pos_next = pmsfp_pkg::POS_LEN_HI;
                    end else begin
                        pos_next = pmsfp_pkg::POS_SYNC_A;
                    end
                end
                pmsfp_pkg::POS_LEN_HI: begin
                    sum_next    = sum_add;
                    len_hi_next = rx_byte;
                    pos_next    = pmsfp_pkg::POS_LEN_LO;
                end
                pmsfp_pkg::POS_LEN_LO: begin
                    if (len_word == pmsfp_pkg::LEN_SHORT ||
                        len_word == pmsfp_pkg::LEN_LONG) begin
                        long_next = (len_word == pmsfp_pkg::LEN_LONG);
                        sum_next  = sum_add;
                        pos_next  = pmsfp_pkg::POS_PAYLOAD;
                    end else begin
                        pos_next = pmsfp_pkg::POS_SYNC_A;
                    end
                end
                default: begin
                    if (pos_reg == ck_pos) begin
                        ck_hi_next = rx_byte;
                        pos_next   = pos_reg + 5'd1;
                    end else if (pos_reg == ck_pos + 5'd1) begin
                        start    = ({ck_hi_reg, rx_byte} == sum_reg);
                        pos_next = pmsfp_pkg::POS_SYNC_A;
                    end else begin
                        sum_next = sum_add;
                        wr.en    = 1'b1;
                        pos_next = pos_reg + 5'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= pmsfp_pkg::POS_SYNC_A;
            sum_reg    <= '0;
            len_hi_reg <= '0;
            long_reg   <= 1'b0;
            ck_hi_reg  <= '0;
        end else begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            len_hi_reg <= len_hi_next;
            long_reg   <= long_next;
            ck_hi_reg  <= ck_hi_next;
        end
    end

endmodule

// File: hw/rtl/pmsfp_emitter.sv
`timescale 1ns / 1ps

`include "pm_sensor_frame_parser_assert.svh"

// Walks the 15 results: reads one word per cycle from the store while the output
// is not stalled, scales the derived ones by reciprocal multiply and holds each in the output register.
module pmsfp_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [15:0]        rd_word,
    output pmsfp_pkg::pay_rd_t rd,
    output logic               busy,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [3:0]         out_index,
    output logic [15:0]        out_value,
    output logic               out_last
);

    pmsfp_pkg::emit_state_t state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic        m_vld_reg, m_vld_next;
    logic [3:0]  m_idx_reg;
    logic [15:0] m_val_reg;
    logic        m_last_reg;

    logic        load;
    logic [16:0] mult_k;
    logic [32:0] prod;
    logic [15:0] quo;
    logic [15:0] value;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        load       = 1'b0;
        rd.en      = 1'b0;
        rd.word    = pmsfp_pkg::word_of(idx_reg);
        unique case (state_reg)
            pmsfp_pkg::EM_IDLE: begin
                if (start) begin
                    idx_next   = '0;
                    state_next = pmsfp_pkg::EM_READ;
                end
            end
            pmsfp_pkg::EM_READ: begin
                rd.en      = 1'b1;
                state_next = pmsfp_pkg::EM_OUT;
            end
            pmsfp_pkg::EM_OUT: begin
                load = !m_vld_reg || m_tready;
                if (load) begin
                    if (idx_reg == pmsfp_pkg::LAST_INDEX) begin
                        state_next = pmsfp_pkg::EM_IDLE;
                    end else begin
                        // fetch the next word as this one moves out
                        idx_next = idx_reg + 4'd1;
                        rd.en    = 1'b1;
                        rd.word  = pmsfp_pkg::word_of(idx_reg + 4'd1);
                    end
                end
            end
            default: begin
                state_next = pmsfp_pkg::EM_IDLE;
            end
        endcase
    end

    assign mult_k = (idx_reg == pmsfp_pkg::HCHO_INDEX) ? pmsfp_pkg::HCHO_MULT
                                                       : pmsfp_pkg::TH_MULT;
    assign prod   = 33'(rd_word) * 33'(mult_k);
    assign quo    = (idx_reg == pmsfp_pkg::HCHO_INDEX) ? 16'(prod >> pmsfp_pkg::HCHO_SHIFT)
                                                       : 16'(prod >> pmsfp_pkg::TH_SHIFT);
    assign value  = (idx_reg < pmsfp_pkg::HCHO_INDEX) ? rd_word : quo;

    always_comb begin
        m_vld_next = m_vld_reg;
        if (m_tready) begin
            m_vld_next = 1'b0;
        end
        if (load) begin
            m_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmsfp_pkg::EM_IDLE;
            idx_reg   <= '0;
            m_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_idx_reg  <= idx_reg;
            m_val_reg  <= value;
            m_last_reg <= (idx_reg == pmsfp_pkg::LAST_INDEX);
        end
    end

    assign busy      = (state_reg != pmsfp_pkg::EM_IDLE);
    assign m_tvalid  = m_vld_reg;
    assign out_index = m_idx_reg;
    assign out_value = m_val_reg;
    assign out_last  = m_last_reg;

    `PMSFP_ASSERT(a_start_when_idle, aclk, aresetn, start |-> state_reg == pmsfp_pkg::EM_IDLE)
    `PMSFP_ASSERT(a_read_after_start, aclk, aresetn, state_reg == pmsfp_pkg::EM_READ |-> $past(start))
    `PMSFP_ASSERT(a_idx_bounded, aclk, aresetn, state_reg == pmsfp_pkg::EM_OUT |-> idx_reg <= pmsfp_pkg::LAST_INDEX)
    `PMSFP_ASSERT(a_last_frees_input, aclk, aresetn, load && out_last == 1'b0 && idx_reg == pmsfp_pkg::LAST_INDEX |=> !busy)

endmodule

// File: hw/rtl/pm_sensor_frame_parser.sv
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// s_       in   8      rx_byte[7:0]
// m_       out  24     word_index[3:0], word_value[19:4], zero pad; tlast = last
//
// One received byte is taken per cycle while no frame is being reported.
// A good checksum starts the report of 15 results, one word read per cycle
// from the two-bank payload RAM unless m_tready stalls it, s_tready low meanwhile.
// m_tready low holds the current result and stops the report where it is.
// Reset is synchronous, aresetn low; the payload reads as zero until written.
module pm_sensor_frame_parser #(
    parameter int PAYLOAD_BYTES = 26
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] word_index, [19:4] word_value
    output logic        m_tlast
);

    pmsfp_pkg::pay_wr_t wr;
    pmsfp_pkg::pay_rd_t rd;
    logic        accept;
    logic        start;
    logic        busy;
    logic [15:0] rd_word;
    logic [3:0]  out_index;
    logic [15:0] out_value;

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    pmsfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .wr      (wr),
        .start   (start)
    );

    pmsfp_store #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd),
        .rd_word (rd_word)
    );

    pmsfp_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .rd_word   (rd_word),
        .rd        (rd),
        .busy      (busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'h0, out_value, out_index};

endmodule
